// ----- rtl/srs_pkg.sv -----
package srs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PITCH_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int OUT_W    = 16;

    // gain is Q1.15
    localparam int GAIN_FRAC = 15;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic valid;
        logic last;
    } t_issue;

endpackage

// ----- rtl/srs_if.sv -----
interface srs_in_if;
    logic                          valid;
    logic                          ready;
    logic [srs_pkg::SAMPLE_W-1:0]  sample_left;
    logic [srs_pkg::SAMPLE_W-1:0]  sample_right;
    logic [srs_pkg::PITCH_W-1:0]   pitch_step;
    logic [srs_pkg::GAIN_W-1:0]    gain;
    logic                          end_of_stream;

    modport source (
        output valid, sample_left, sample_right, pitch_step, gain, end_of_stream,
        input  ready
    );
    modport sink (
        input  valid, sample_left, sample_right, pitch_step, gain, end_of_stream,
        output ready
    );
endinterface

interface srs_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [srs_pkg::OUT_W-1:0]   out_left;
    logic signed [srs_pkg::OUT_W-1:0]   out_right;
    logic                               last_of_run;

    modport source (
        output valid, out_left, out_right, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_right, last_of_run,
        output ready
    );
endinterface

// ----- rtl/srs_lane.sv -----
module srs_lane #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [srs_pkg::SAMPLE_W-1:0]        i_lo,
    input  logic [srs_pkg::SAMPLE_W-1:0]        i_hi,
    input  logic [FRAC_BITS-1:0]                i_ph,
    input  logic [srs_pkg::GAIN_W-1:0]          i_gain,
    output logic signed [srs_pkg::OUT_W-1:0]    o_res
);

    localparam int V_W    = srs_pkg::SAMPLE_W + FRAC_BITS;
    localparam int T_W    = FRAC_BITS + srs_pkg::SAMPLE_W + 2;
    localparam int P_W    = V_W + srs_pkg::GAIN_W;
    localparam int SHIFT  = FRAC_BITS + srs_pkg::GAIN_FRAC;
    localparam int S_W    = P_W - SHIFT;

    logic signed [srs_pkg::SAMPLE_W:0]  diff;
    logic signed [T_W-1:0]              term;
    logic signed [T_W-1:0]              v_full;
    logic [V_W-1:0]                     n_v;
    logic [V_W-1:0]                     r_v;
    logic [srs_pkg::GAIN_W-1:0]         r_g;
    logic [P_W-1:0]                     r_p;
    logic [S_W-1:0]                     s;

    // lo + ph*(hi-lo) in Q16.FRAC, never negative
    assign diff   = $signed({1'b0, i_hi}) - $signed({1'b0, i_lo});
    assign term   = T_W'($signed({1'b0, i_ph})) * T_W'(diff);
    assign v_full = $signed({2'b00, i_lo, {FRAC_BITS{1'b0}}}) + term;
    assign n_v    = v_full[V_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_g <= i_gain;
            r_p <= P_W'(r_v) * P_W'(r_g);
        end
    end

    // truncate, remove the offset, clip the top
    assign s = r_p[P_W-1:SHIFT];

    always_comb begin
        if (s >= S_W'(65535)) begin
            o_res = {1'b0, {(srs_pkg::OUT_W-1){1'b1}}};
        end else begin
            o_res = signed'(srs_pkg::OUT_W'(s - S_W'(32768)));
        end
    end

endmodule

// ----- rtl/srs_seq.sv -----
module srs_seq #(
    parameter int FRAC_BITS = 14,
    parameter int MAX_RUN   = 64,
    parameter int PH_W      = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    srs_in_if.sink                          i_src,
    input  logic                            i_en,
    output srs_pkg::t_issue                 o_issue,
    output logic [srs_pkg::SAMPLE_W-1:0]    o_lo_l,
    output logic [srs_pkg::SAMPLE_W-1:0]    o_hi_l,
    output logic [srs_pkg::SAMPLE_W-1:0]    o_lo_r,
    output logic [srs_pkg::SAMPLE_W-1:0]    o_hi_r,
    output logic [FRAC_BITS-1:0]            o_ph,
    output logic [srs_pkg::GAIN_W-1:0]      o_gain
);

    localparam int CNT_W = $clog2(MAX_RUN);
    localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << FRAC_BITS;
    localparam logic [srs_pkg::PITCH_W-1:0] PITCH_MIN =
        srs_pkg::PITCH_W'(1) << (FRAC_BITS - 6);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RUN - 1);

    srs_pkg::t_state                r_state, n_state;
    logic                           r_primed, n_primed;
    logic                           r_flush, n_flush;
    logic [srs_pkg::SAMPLE_W-1:0]   r_older_l, n_older_l, r_older_r, n_older_r;
    logic [srs_pkg::SAMPLE_W-1:0]   r_newer_l, n_newer_l, r_newer_r, n_newer_r;
    logic [PH_W-1:0]                r_phase, n_phase;
    logic [srs_pkg::PITCH_W-1:0]    r_pitch, n_pitch;
    logic [srs_pkg::GAIN_W-1:0]     r_gain, n_gain;
    logic [CNT_W-1:0]               r_cnt, n_cnt;

    logic                           acc;
    logic [PH_W-1:0]                ph_sum;
    logic [PH_W-1:0]                ph_dec;
    logic                           last;

    assign i_src.ready = (r_state == srs_pkg::ST_IDLE);
    assign acc         = i_src.valid && i_src.ready;
    assign ph_sum      = r_phase + PH_W'(r_pitch);
    assign ph_dec      = (r_phase >= PH_ONE) ? (r_phase - PH_ONE) : '0;
    assign last        = r_flush || (ph_sum >= PH_ONE) || (r_cnt == CNT_LAST);

    assign o_issue = {(r_state == srs_pkg::ST_RUN), last};
    assign o_lo_l = r_older_l;
    assign o_hi_l = r_newer_l;
    assign o_lo_r = r_older_r;
    assign o_hi_r = r_newer_r;
    assign o_ph   = r_phase[FRAC_BITS-1:0];
    assign o_gain = r_gain;

    always_comb begin
        n_state   = r_state;
        n_primed  = r_primed;
        n_flush   = r_flush;
        n_older_l = r_older_l;
        n_older_r = r_older_r;
        n_newer_l = r_newer_l;
        n_newer_r = r_newer_r;
        n_phase   = r_phase;
        n_pitch   = r_pitch;
        n_gain    = r_gain;
        n_cnt     = r_cnt;
        case (r_state)
            srs_pkg::ST_IDLE: begin
                if (acc) begin
                    n_cnt  = '0;
                    n_gain = i_src.gain;
                    if (i_src.end_of_stream) begin
                        n_primed = 1'b0;
                        if (r_primed) begin
                            // one last output of the older sample
                            n_flush   = 1'b1;
                            n_newer_l = r_older_l;
                            n_newer_r = r_older_r;
                            n_phase   = '0;
                            n_state   = srs_pkg::ST_RUN;
                        end else begin
                            n_older_l = '0;
                            n_older_r = '0;
                            n_newer_l = '0;
                            n_newer_r = '0;
                            n_phase   = '0;
                        end
                    end else if (!r_primed) begin
                        n_older_l = i_src.sample_left;
                        n_older_r = i_src.sample_right;
                        n_newer_l = i_src.sample_left;
                        n_newer_r = i_src.sample_right;
                        n_phase   = PH_ONE;
                        n_primed  = 1'b1;
                    end else begin
                        n_older_l = r_newer_l;
                        n_older_r = r_newer_r;
                        n_newer_l = i_src.sample_left;
                        n_newer_r = i_src.sample_right;
                        n_phase   = ph_dec;
                        n_pitch   = (i_src.pitch_step < PITCH_MIN) ? PITCH_MIN
                                                                   : i_src.pitch_step;
                        if (ph_dec < PH_ONE) begin
                            n_state = srs_pkg::ST_RUN;
                        end
                    end
                end
            end
            srs_pkg::ST_RUN: begin
                if (i_en) begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_phase = ph_sum;
                    if (last) begin
                        n_state = srs_pkg::ST_IDLE;
                        n_flush = 1'b0;
                        if (r_flush) begin
                            n_older_l = '0;
                            n_older_r = '0;
                            n_newer_l = '0;
                            n_newer_r = '0;
                            n_phase   = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = srs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srs_pkg::ST_IDLE;
            r_primed  <= 1'b0;
            r_flush   <= 1'b0;
            r_older_l <= '0;
            r_older_r <= '0;
            r_newer_l <= '0;
            r_newer_r <= '0;
            r_phase   <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_primed  <= n_primed;
            r_flush   <= n_flush;
            r_older_l <= n_older_l;
            r_older_r <= n_older_r;
            r_newer_l <= n_newer_l;
            r_newer_r <= n_newer_r;
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pitch <= n_pitch;
        r_gain  <= n_gain;
    end

    a_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srs_pkg::ST_RUN && !r_flush) |-> (r_phase < PH_ONE))
        else $error("interpolation phase not below one during a run");

    a_eos_unprimes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_src.end_of_stream) |=> !r_primed)
        else $error("block still primed after end of stream");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_issue.valid && r_flush) |-> o_issue.last)
        else $error("flush output not marked last");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_issue.valid && r_cnt == CNT_LAST) |-> o_issue.last)
        else $error("run exceeds its output limit");

endmodule

// ----- rtl/srs_merge.sv -----
module srs_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srs_pkg::t_issue                     i_issue,
    input  logic signed [srs_pkg::OUT_W-1:0]    i_res_l,
    input  logic signed [srs_pkg::OUT_W-1:0]    i_res_r,
    output logic                                o_en,
    srs_out_if.source                           o_res
);

    srs_pkg::t_issue                    r_t1, r_t2;
    logic                               r_ov;
    logic                               r_last;
    logic signed [srs_pkg::OUT_W-1:0]   r_out_l, r_out_r;

    // hold the whole pipe while a finished result waits
    assign o_en = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_ov <= 1'b0;
        end else if (o_en) begin
            r_t1 <= i_issue;
            r_t2 <= r_t1;
            r_ov <= r_t2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_last  <= r_t2.last;
            r_out_l <= i_res_l;
            r_out_r <= i_res_r;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.last_of_run = r_last;
    assign o_res.out_left    = r_out_l;
    assign o_res.out_right   = r_out_r;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_en) |=> (r_t1 == $past(r_t1) && r_t2 == $past(r_t2)))
        else $error("pipeline tags moved during a stall");

endmodule

// ----- rtl/stereo_linear_interp_resampler_top.sv -----
// A result is registered in the sequencer, in each lane (r_v, then r_p) and in
// the merge output stage. The input is not ready while an item's results (0 to
// MAX_RUN) are issued; unless stalled, the sequencer issues one result per cycle.
// Output stalls hold the whole interpolation pipe and the sequencer.
// Reset (synchronous, active low) empties the pipe and leaves the block unprimed.
module stereo_linear_interp_resampler_top #(
    parameter int FRAC_BITS = 14,
    parameter int MAX_RUN   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srs_in_if.sink      i_src,
    srs_out_if.source   o_res
);

    localparam int PH_W = ((FRAC_BITS > srs_pkg::PITCH_W) ? FRAC_BITS
                                                           : srs_pkg::PITCH_W) + 1;

    srs_pkg::t_issue                    issue;
    logic                               en;
    logic [srs_pkg::SAMPLE_W-1:0]       lo_l, hi_l, lo_r, hi_r;
    logic [FRAC_BITS-1:0]               ph;
    logic [srs_pkg::GAIN_W-1:0]         gain;
    logic signed [srs_pkg::OUT_W-1:0]   res_l, res_r;

    srs_seq #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_RUN   (MAX_RUN),
        .PH_W      (PH_W)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_en    (en),
        .o_issue (issue),
        .o_lo_l  (lo_l),
        .o_hi_l  (hi_l),
        .o_lo_r  (lo_r),
        .o_hi_r  (hi_r),
        .o_ph    (ph),
        .o_gain  (gain)
    );

    srs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_l (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lo   (lo_l),
        .i_hi   (hi_l),
        .i_ph   (ph),
        .i_gain (gain),
        .o_res  (res_l)
    );

    srs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lo   (lo_r),
        .i_hi   (hi_r),
        .i_ph   (ph),
        .i_gain (gain),
        .o_res  (res_r)
    );

    srs_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_res_l (res_l),
        .i_res_r (res_r),
        .o_en    (en),
        .o_res   (o_res)
    );

endmodule

// ----- bench/tb_resampler_pkg.sv -----
`timescale 1ns / 1ps

package tb_resampler_pkg;

    localparam int FRAC_BITS = 14;
    localparam int MAX_RUN   = 64;
    localparam int PH_ONE    = 1 << FRAC_BITS;
    localparam int PITCH_MIN = 1 << (FRAC_BITS - 6);

    typedef struct {
        bit [srs_pkg::SAMPLE_W-1:0] left;
        bit [srs_pkg::SAMPLE_W-1:0] right;
        bit [srs_pkg::PITCH_W-1:0]  pitch;
        bit [srs_pkg::GAIN_W-1:0]   gain;
        bit                         eos;
    } t_source_item;

    typedef struct {
        bit [srs_pkg::OUT_W-1:0] left;
        bit [srs_pkg::OUT_W-1:0] right;
        bit                      last;
    } t_stereo_out;

    class resample_scoreboard;
        bit [srs_pkg::SAMPLE_W-1:0] older_l, older_r, newer_l, newer_r;
        bit [16:0]                  phase;
        bit                         primed;
        t_stereo_out                pending_outputs[$];
        int                         errors;
        int                         inputs_taken;

        function new();
            clear_state();
            errors = 0;
            inputs_taken = 0;
        endfunction

        function void clear_state();
            older_l = '0;
            older_r = '0;
            newer_l = '0;
            newer_r = '0;
            phase   = '0;
            primed  = 1'b0;
        endfunction

        // Exact blend of lo and hi at ph, scaled by gain, truncated, made signed.
        function bit [srs_pkg::OUT_W-1:0] interp_scale(bit [srs_pkg::SAMPLE_W-1:0] lo,
                                                       bit [srs_pkg::SAMPLE_W-1:0] hi,
                                                       bit [16:0] ph,
                                                       bit [srs_pkg::GAIN_W-1:0] g);
            longint unsigned blend;
            longint unsigned scaled;
            longint          signed_val;
            blend = longint'(lo) * longint'(PH_ONE - int'(ph)) + longint'(hi) * longint'(ph);
            scaled = (blend * longint'(g)) >> (FRAC_BITS + srs_pkg::GAIN_FRAC);
            signed_val = longint'(scaled) - 32768;
            if (signed_val > 32767)
                signed_val = 32767;
            return signed_val[srs_pkg::OUT_W-1:0];
        endfunction

        function void take_source(t_source_item it);
            t_stereo_out o;
            bit [16:0]   step;
            int          n;
            inputs_taken++;
            if (it.eos) begin
                if (primed) begin
                    o.left  = interp_scale(older_l, older_l, '0, it.gain);
                    o.right = interp_scale(older_r, older_r, '0, it.gain);
                    o.last  = 1'b1;
                    pending_outputs.push_back(o);
                end
                clear_state();
                return;
            end
            if (!primed) begin
                older_l = it.left;
                older_r = it.right;
                newer_l = it.left;
                newer_r = it.right;
                phase   = 17'(PH_ONE);
                primed  = 1'b1;
                return;
            end
            step = (it.pitch < PITCH_MIN) ? 17'(PITCH_MIN) : 17'(it.pitch);
            older_l = newer_l;
            older_r = newer_r;
            newer_l = it.left;
            newer_r = it.right;
            phase = (phase >= PH_ONE) ? 17'(phase - PH_ONE) : '0;
            n = 0;
            while (phase < PH_ONE && n < MAX_RUN) begin
                o.left  = interp_scale(older_l, newer_l, phase, it.gain);
                o.right = interp_scale(older_r, newer_r, phase, it.gain);
                o.last  = 1'b0;
                pending_outputs.push_back(o);
                n++;
                phase = phase + step;
            end
            if (n > 0)
                pending_outputs[pending_outputs.size() - 1].last = 1'b1;
        endfunction

        function void match_output(bit [srs_pkg::OUT_W-1:0] l, bit [srs_pkg::OUT_W-1:0] r,
                                   bit last);
            t_stereo_out want;
            if (pending_outputs.size() == 0) begin
                $error("unexpected output transaction: out_left %0d out_right %0d last %0b",
                       $signed(l), $signed(r), last);
                errors++;
                return;
            end
            want = pending_outputs.pop_front();
            if (want.left !== l) begin
                $error("out_left: expected %0d, actual %0d", $signed(want.left), $signed(l));
                errors++;
            end
            if (want.right !== r) begin
                $error("out_right: expected %0d, actual %0d", $signed(want.right), $signed(r));
                errors++;
            end
            if (want.last !== last) begin
                $error("last_of_run: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 150;
    localparam int RANDOM_ITEMS = 290;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    srs_in_if  src_if ();
    srs_out_if res_if ();

    stereo_linear_interp_resampler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if.sink),
        .o_res   (res_if.source)
    );

    tb_resampler_pkg::resample_scoreboard sb = new();

    int burst_left = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic tb_resampler_pkg::t_source_item mk(int l, int r, int p, int g, bit e);
        tb_resampler_pkg::t_source_item it;
        it.left  = l[15:0];
        it.right = r[15:0];
        it.pitch = p[15:0];
        it.gain  = g[15:0];
        it.eos   = e;
        return it;
    endfunction

    function automatic tb_resampler_pkg::t_source_item random_item();
        tb_resampler_pkg::t_source_item it;
        int sel;
        it.left  = 16'($urandom());
        it.right = 16'($urandom());
        sel = $urandom_range(0, 9);
        if (sel == 0)
            it.pitch = 16'($urandom_range(0, tb_resampler_pkg::PITCH_MIN - 1));
        else if (sel <= 5)
            it.pitch = 16'($urandom_range(tb_resampler_pkg::PITCH_MIN, 8192));
        else if (sel <= 8)
            it.pitch = 16'($urandom_range(8192, 32768));
        else
            it.pitch = 16'($urandom());
        it.gain = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                               : 16'($urandom_range(0, 32768));
        it.eos  = ($urandom_range(0, 24) == 0);
        return it;
    endfunction

    // Offer one item, wait for its transaction, then pace the sender in bursts.
    task automatic send_item(tb_resampler_pkg::t_source_item it);
        int gap;
        src_if.valid         <= 1'b1;
        src_if.sample_left   <= it.left;
        src_if.sample_right  <= it.right;
        src_if.pitch_step    <= it.pitch;
        src_if.gain          <= it.gain;
        src_if.end_of_stream <= it.eos;
        @(posedge i_clk);
        while (!src_if.ready)
            @(posedge i_clk);
        sb.take_source(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                src_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        tb_resampler_pkg::t_source_item directed[$];
        i_rst_n              <= 1'b0;
        src_if.valid         <= 1'b0;
        src_if.sample_left   <= '0;
        src_if.sample_right  <= '0;
        src_if.pitch_step    <= '0;
        src_if.gain          <= '0;
        src_if.end_of_stream <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // end while unprimed, then prime
        directed.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 32768, 1'b1));
        directed.push_back(mk(0, 16'hFFFF, 4096, 32768, 1'b0));
        directed.push_back(mk(16'hFFFF, 0, 4096, 32768, 1'b0));
        // pitch below the floor gives the longest run
        directed.push_back(mk(16'h8000, 16'h8000, 0, 32768, 1'b0));
        directed.push_back(mk(16'h1234, 16'hFEDC, 255, 0, 1'b0));
        directed.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        // phase still above one: no outputs
        directed.push_back(mk(16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF, 1'b0));
        directed.push_back(mk(16'h5555, 16'hAAAA, 16384, 16'hFFFF, 1'b0));
        directed.push_back(mk(16'hFFFF, 16'hFFFF, 16384, 16'hFFFF, 1'b0));
        directed.push_back(mk(0, 0, 1, 1, 1'b0));
        directed.push_back(mk(16'hFFFF, 0, 256, 40000, 1'b0));
        directed.push_back(mk(16'h0F0F, 16'hF0F0, 8192, 32768, 1'b1));
        directed.push_back(mk(0, 0, 0, 0, 1'b1));
        // prime then flush straight away
        directed.push_back(mk(16'hC000, 16'h3FFF, 16384, 32768, 1'b0));
        directed.push_back(mk(16'h0001, 16'hFFFE, 0, 16'hFFFF, 1'b1));
        directed.push_back(mk(16'h7FFF, 16'h8000, 12000, 32767, 1'b0));
        directed.push_back(mk(16'h8000, 16'h7FFF, 16384, 32767, 1'b0));
        directed.push_back(mk(0, 16'hFFFF, 32768, 32768, 1'b0));
        directed.push_back(mk(16'hFFFF, 0, 5461, 16384, 1'b0));
        directed.push_back(mk(16'h2468, 16'h1357, 1000, 0, 1'b1));

        foreach (directed[k])
            send_item(directed[k]);
        repeat (RANDOM_ITEMS)
            send_item(random_item());
        src_if.valid <= 1'b0;

        while (sb.pending_outputs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_outputs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Output side: check each transaction, stall on a rotating pattern.
    initial begin
        int  cyc;
        int  hold_left;
        bit  hold_used;
        cyc       = 0;
        hold_left = 0;
        hold_used = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                sb.match_output(res_if.out_left, res_if.out_right, res_if.last_of_run);
            cyc++;
            // hold off for a long stretch so the input side backs up
            if (!hold_used && sb.inputs_taken >= HOLD_AT) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                case ((cyc / 64) % 4)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 3) != 0);
                    2: res_if.ready <= (cyc % 3 != 0);
                    default: res_if.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((src_if.valid && src_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
rtl/srs_pkg.sv
rtl/srs_if.sv
rtl/srs_lane.sv
rtl/srs_seq.sv
rtl/srs_merge.sv
rtl/stereo_linear_interp_resampler_top.sv
bench/tb_resampler_pkg.sv
bench/tb_top.sv
